>>> hw/rtl/rbi_pkg.sv
// Shared types, codes and arithmetic helpers for the 2D rigid body integrator.
`timescale 1ns / 1ps
package rbi_pkg;

  // Fixed point formats.
  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;

  // Item kinds.
  localparam logic [3:0] K_TICK   = 4'd0;
  localparam logic [3:0] K_ADDF   = 4'd1;
  localparam logic [3:0] K_SETF   = 4'd2;
  localparam logic [3:0] K_IMP    = 4'd3;
  localparam logic [3:0] K_QVEL   = 4'd4;
  localparam logic [3:0] K_STOP   = 4'd5;
  localparam logic [3:0] K_DZX    = 4'd6;
  localparam logic [3:0] K_DZY    = 4'd7;
  localparam logic [3:0] K_ZX     = 4'd8;
  localparam logic [3:0] K_ZY     = 4'd9;
  localparam logic [3:0] K_NORMAL = 4'd10;
  localparam logic [3:0] K_BRAKE  = 4'd11;
  localparam logic [3:0] K_PRED   = 4'd12;
  localparam logic [3:0] K_LOAD   = 4'd13;

  // Configuration register indexes.
  localparam logic [3:0] R_GRAV     = 4'd0;
  localparam logic [3:0] R_GRAV_EN  = 4'd1;
  localparam logic [3:0] R_FRIC_X   = 4'd2;
  localparam logic [3:0] R_FRIC_Y   = 4'd3;
  localparam logic [3:0] R_FRIC_EN  = 4'd4;
  localparam logic [3:0] R_SPD_LIM  = 4'd5;
  localparam logic [3:0] R_MASS     = 4'd6;
  localparam logic [3:0] R_BRAKE    = 4'd7;

  // Arithmetic unit operations.
  typedef logic [2:0] alu_op_t;
  localparam alu_op_t OP_MUL   = 3'd0;  // wide product a*b
  localparam alu_op_t OP_SHR16 = 3'd1;  // (a*b) >> 16, signed by neg
  localparam alu_op_t OP_SHR30 = 3'd2;  // (a*b) >> 30, signed by neg
  localparam alu_op_t OP_DIV   = 3'd3;  // (a*b) / c, signed by neg
  localparam alu_op_t OP_NORM  = 3'd4;  // a*a + b*b and its floor root
  localparam alu_op_t OP_SQRT  = 3'd5;  // floor root of rad

  // Constants of the behavior.
  localparam logic [30:0] MASS_MIN  = 31'd7;
  localparam logic [31:0] SNAP_LVL  = 32'd655;
  localparam logic [63:0] NORM_LIM  = 64'd429496;
  localparam logic [16:0] FR_ONE    = 17'd65536;
  localparam logic [30:0] SPEED_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    alu_op_t     op;
    logic        neg;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [63:0] rad;
  } alu_req_t;

  // Magnitude of a signed word.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

  // Sign and saturate a wide magnitude into a signed word.
  function automatic logic signed [31:0] sat_word(input logic neg, input logic [63:0] m);
    logic [31:0] lo;
    lo = m[31:0];
    if (m == 64'd0) return '0;
    if (neg) begin
      if (m > 64'h80000000) return 32'sh80000000;
      return ~lo + 32'd1;
    end
    if (m > 64'h7FFFFFFF) return 32'sh7FFFFFFF;
    return lo;
  endfunction

  // Saturating signed add.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return s[31:0];
  endfunction

endpackage

>>> hw/rtl/rbi_if.sv
// Channel interfaces of the 2D rigid body integrator: item in, result out, config write.
`timescale 1ns / 1ps
interface rbi_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [15:0]        time_step;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] magnitude;
  logic               positive_side;
  modport source (output valid, kind, time_step, vec_x, vec_y, magnitude, positive_side,
                  input ready);
  modport sink (input valid, kind, time_step, vec_x, vec_y, magnitude, positive_side,
                output ready);
endinterface

interface rbi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic [30:0]        speed;
  logic signed [31:0] predicted_x;
  logic signed [31:0] predicted_y;
  modport source (output valid, position_x, position_y, velocity_x, velocity_y, speed,
                  predicted_x, predicted_y, input ready);
  modport sink (input valid, position_x, position_y, velocity_x, velocity_y, speed,
                predicted_x, predicted_y, output ready);
endinterface

interface rbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_index;
  logic [31:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

>>> hw/rtl/rbi_alu.sv
// Shared iterative arithmetic unit: multiply, shift, restoring divide and floor square root.
`timescale 1ns / 1ps
module rbi_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rbi_pkg::alu_req_t  req,
  output logic               done,
  output logic signed [31:0] res_word,
  output logic [63:0]        res_wide,
  output logic [31:0]        res_root
);
  import rbi_pkg::*;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL1 = 3'd1;
  localparam logic [2:0] A_MUL2 = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_SQRT = 3'd4;
  localparam logic [2:0] A_FIN  = 3'd5;

  logic [2:0]         st_r, st_nxt;
  alu_req_t           req_r, req_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [63:0]        work_r, work_nxt;
  logic [35:0]        rem_r, rem_nxt;
  logic [31:0]        root_r, root_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic signed [31:0] word_r, word_nxt;
  logic [63:0]        wide_r, wide_nxt;
  logic [31:0]        rroot_r, rroot_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] div_sh, div_diff;
  logic        div_ge;
  logic [35:0] sq_sh, sq_trial, sq_diff;
  logic        sq_ge;

  // The one multiplier, fed by the phase of the operation.
  always_comb begin
    mul_a = req_r.a;
    mul_b = (st_r == A_MUL1 && req_r.op != OP_NORM) ? req_r.b : req_r.a;
    if (st_r == A_MUL2) begin
      mul_a = req_r.b;
      mul_b = req_r.b;
    end
    mul_p = mul_a * mul_b;
  end

  // One quotient bit and one root bit per cycle.
  always_comb begin
    div_sh   = {rem_r[31:0], work_r[63]};
    div_ge   = div_sh >= {1'b0, req_r.c};
    div_diff = div_sh - {1'b0, req_r.c};
    sq_sh    = {rem_r[33:0], work_r[63:62]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
  end

  // Sequencing of the unit.
  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    word_nxt  = word_r;
    wide_nxt  = wide_r;
    rroot_nxt = rroot_r;
    case (st_r)
      A_IDLE: begin
        if (start) begin
          req_nxt = req;
          if (req.op == OP_SQRT) begin
            work_nxt = req.rad;
            sum_nxt  = req.rad;
            rem_nxt  = '0;
            root_nxt = '0;
            cnt_nxt  = 6'd31;
            st_nxt   = A_SQRT;
          end else begin
            st_nxt = A_MUL1;
          end
        end
      end
      A_MUL1: begin
        prod_nxt = mul_p;
        st_nxt   = A_MUL2;
      end
      A_MUL2: begin
        st_nxt = A_FIN;
        case (req_r.op)
          OP_NORM: begin
            sum_nxt  = prod_r + mul_p;
            work_nxt = prod_r + mul_p;
            rem_nxt  = '0;
            root_nxt = '0;
            cnt_nxt  = 6'd31;
            st_nxt   = A_SQRT;
          end
          OP_SHR16: work_nxt = prod_r >> 16;
          OP_SHR30: work_nxt = prod_r >> 30;
          OP_DIV: begin
            if (req_r.c == 32'd0) begin
              work_nxt = '0;
            end else begin
              work_nxt = prod_r;
              rem_nxt  = '0;
              cnt_nxt  = 6'd63;
              st_nxt   = A_DIV;
            end
          end
          default: work_nxt = prod_r;
        endcase
      end
      A_DIV: begin
        rem_nxt  = {3'b000, div_ge ? div_diff : div_sh};
        work_nxt = {work_r[62:0], div_ge};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) st_nxt = A_FIN;
      end
      A_SQRT: begin
        rem_nxt  = sq_ge ? sq_diff : sq_sh;
        root_nxt = {root_r[30:0], sq_ge};
        work_nxt = {work_r[61:0], 2'b00};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) st_nxt = A_FIN;
      end
      A_FIN: begin
        word_nxt  = sat_word(req_r.neg, work_r);
        wide_nxt  = (req_r.op == OP_NORM || req_r.op == OP_SQRT) ? sum_r : prod_r;
        rroot_nxt = root_r;
        done_nxt  = 1'b1;
        st_nxt    = A_IDLE;
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    req_r   <= req_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    word_r  <= word_nxt;
    wide_r  <= wide_nxt;
    rroot_r <= rroot_nxt;
  end

  assign done     = done_r;
  assign res_word = word_r;
  assign res_wide = wide_r;
  assign res_root = rroot_r;

endmodule

>>> hw/rtl/rigid_body_2d_integrator_unit.sv
// Top level of the 2D rigid body integrator: body state, sequencer and channels.
`timescale 1ns / 1ps
// Keeps position, velocity and one queued velocity of a single 2D body in signed Q16.16.
// in_chan takes one word per item (kind and operands); out_chan returns one word per
// item with position, velocity, speed and, for a predict item, the predicted position.
// cfg_chan writes the registers (gravity, friction, speed limit, mass, brake rate); it
// is always ready and is meant to be written while no item is in flight.
// One item is in flight at a time: in_chan.ready is high only while the sequencer idles.
// All arithmetic goes through one shared unit (32x32 multiplier, one-bit-per-cycle
// divider, one-bit-per-cycle square root), so latency is set by the number of unit
// calls. For a tick with friction, each axis runs sixteen square roots and up to
// sixteen multiplies for (1-f)^dt.
// The result sits in an output register until out_chan.ready is seen; a stalled
// receiver holds the block, and in_chan is ready again in the cycle after delivery.
// Reset (rst_n low, synchronous) clears the body state and queued velocity and loads
// the register defaults: speed limit at its maximum and mass 1.0.
module rigid_body_2d_integrator_unit (
  input logic     clk,
  input logic     rst_n,
  rbi_in_if.sink  in_chan,
  rbi_out_if.source out_chan,
  rbi_cfg_if.sink cfg_chan
);
  import rbi_pkg::*;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_TQ     = 6'd1;
  localparam logic [5:0] S_GRAV   = 6'd2;
  localparam logic [5:0] S_FINIT  = 6'd3;
  localparam logic [5:0] S_FSQRT  = 6'd4;
  localparam logic [5:0] S_FMUL   = 6'd5;
  localparam logic [5:0] S_FAPPLY = 6'd6;
  localparam logic [5:0] S_CNORM  = 6'd7;
  localparam logic [5:0] S_CLIM   = 6'd8;
  localparam logic [5:0] S_CX     = 6'd9;
  localparam logic [5:0] S_CY     = 6'd10;
  localparam logic [5:0] S_MVX    = 6'd11;
  localparam logic [5:0] S_MVY    = 6'd12;
  localparam logic [5:0] S_ACC    = 6'd13;
  localparam logic [5:0] S_DIRLEN = 6'd14;
  localparam logic [5:0] S_DIRX   = 6'd15;
  localparam logic [5:0] S_DIRY   = 6'd16;
  localparam logic [5:0] S_DIRAPP = 6'd17;
  localparam logic [5:0] S_FDTX   = 6'd18;
  localparam logic [5:0] S_FDTY   = 6'd19;
  localparam logic [5:0] S_NLEN   = 6'd20;
  localparam logic [5:0] S_NDX    = 6'd21;
  localparam logic [5:0] S_NDY    = 6'd22;
  localparam logic [5:0] S_NVX    = 6'd23;
  localparam logic [5:0] S_NVY    = 6'd24;
  localparam logic [5:0] S_BLEN   = 6'd25;
  localparam logic [5:0] S_BDEC   = 6'd26;
  localparam logic [5:0] S_BX     = 6'd27;
  localparam logic [5:0] S_BY     = 6'd28;
  localparam logic [5:0] S_SPD    = 6'd29;
  localparam logic [5:0] S_OUT    = 6'd30;

  // Sequencer and latched item.
  logic [5:0]         state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic [3:0]         kind_r, kind_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, mg_r, mg_nxt;

  // Body state.
  logic signed [31:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [31:0] vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic signed [31:0] qv_x_r, qv_x_nxt, qv_y_r, qv_y_nxt;
  logic               qvalid_r, qvalid_nxt;

  // Configuration registers.
  logic signed [31:0] grav_r, grav_nxt;
  logic               grav_en_r, grav_en_nxt, fric_en_r, fric_en_nxt;
  logic [16:0]        fric_x_r, fric_x_nxt, fric_y_r, fric_y_nxt;
  logic [30:0]        spd_lim_r, spd_lim_nxt, mass_r, mass_nxt, brake_r, brake_nxt;

  // Working registers.
  logic signed [31:0] acc_r, acc_nxt, ax_r, ax_nxt, ay_r, ay_nxt, t0_r, t0_nxt;
  logic signed [31:0] pred_x_r, pred_x_nxt, pred_y_r, pred_y_nxt;
  logic [31:0]        len_r, len_nxt, ns_r, ns_nxt;
  logic [63:0]        sq_r, sq_nxt;
  logic               fax_r, fax_nxt;
  logic [30:0]        fr_r, fr_nxt, fp_r, fp_nxt;
  logic [3:0]         fk_r, fk_nxt;

  // Output register.
  logic               ovalid_r, ovalid_nxt;
  logic signed [31:0] o_px_r, o_px_nxt, o_py_r, o_py_nxt, o_vx_r, o_vx_nxt, o_vy_r, o_vy_nxt;
  logic signed [31:0] o_prx_r, o_prx_nxt, o_pry_r, o_pry_nxt;
  logic [30:0]        o_spd_r, o_spd_nxt;

  // Shared unit.
  logic               alu_start, alu_done;
  alu_req_t           alu_req;
  logic signed [31:0] alu_word;
  logic [63:0]        alu_wide;
  logic [31:0]        alu_root;

  rbi_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (alu_start),
    .req      (alu_req),
    .done     (alu_done),
    .res_word (alu_word),
    .res_wide (alu_wide),
    .res_root (alu_root)
  );

  logic               in_acc, out_acc, call_ok;
  logic signed [31:0] fv, fw, dot;
  logic [16:0]        fsel, fcl;
  logic [31:0]        dec;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign call_ok = pend_r && alu_done;

  // Configuration writes.
  always_comb begin
    grav_nxt    = grav_r;
    grav_en_nxt = grav_en_r;
    fric_x_nxt  = fric_x_r;
    fric_y_nxt  = fric_y_r;
    fric_en_nxt = fric_en_r;
    spd_lim_nxt = spd_lim_r;
    mass_nxt    = mass_r;
    brake_nxt   = brake_r;
    if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.reg_index)
        R_GRAV:    grav_nxt    = cfg_chan.data;
        R_GRAV_EN: grav_en_nxt = cfg_chan.data[0];
        R_FRIC_X:  fric_x_nxt  = cfg_chan.data[16:0];
        R_FRIC_Y:  fric_y_nxt  = cfg_chan.data[16:0];
        R_FRIC_EN: fric_en_nxt = cfg_chan.data[0];
        R_SPD_LIM: spd_lim_nxt = cfg_chan.data[30:0];
        R_MASS:    mass_nxt    = (cfg_chan.data[30:0] < MASS_MIN) ? MASS_MIN
                                                                 : cfg_chan.data[30:0];
        R_BRAKE:   brake_nxt   = cfg_chan.data[30:0];
        default:   ;
      endcase
    end
  end

  // Main sequencer: most steps issue one unit call and consume its result.
  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    dt_nxt     = dt_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    mg_nxt     = mg_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    vel_x_nxt  = vel_x_r;
    vel_y_nxt  = vel_y_r;
    qv_x_nxt   = qv_x_r;
    qv_y_nxt   = qv_y_r;
    qvalid_nxt = qvalid_r;
    acc_nxt    = acc_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    t0_nxt     = t0_r;
    pred_x_nxt = pred_x_r;
    pred_y_nxt = pred_y_r;
    len_nxt    = len_r;
    ns_nxt     = ns_r;
    sq_nxt     = sq_r;
    fax_nxt    = fax_r;
    fr_nxt     = fr_r;
    fp_nxt     = fp_r;
    fk_nxt     = fk_r;
    ovalid_nxt = ovalid_r;
    o_px_nxt   = o_px_r;
    o_py_nxt   = o_py_r;
    o_vx_nxt   = o_vx_r;
    o_vy_nxt   = o_vy_r;
    o_prx_nxt  = o_prx_r;
    o_pry_nxt  = o_pry_r;
    o_spd_nxt  = o_spd_r;
    alu_req    = '0;
    alu_start  = 1'b0;
    fv         = fax_r ? vel_y_r : vel_x_r;
    fw         = '0;
    dot        = sat_add(t0_r, alu_word);
    fsel       = fax_r ? fric_y_r : fric_x_r;
    fcl        = (fsel > FR_ONE) ? FR_ONE : fsel;
    dec        = alu_word;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_chan.kind;
          dt_nxt     = in_chan.time_step;
          vx_nxt     = in_chan.vec_x;
          vy_nxt     = in_chan.vec_y;
          mg_nxt     = in_chan.magnitude;
          pred_x_nxt = '0;
          pred_y_nxt = '0;
          state_nxt  = S_SPD;
          case (in_chan.kind)
            K_TICK:  state_nxt = S_TQ;
            K_ADDF, K_SETF, K_IMP: state_nxt = S_ACC;
            K_QVEL: begin
              qv_x_nxt   = in_chan.vec_x;
              qv_y_nxt   = in_chan.vec_y;
              qvalid_nxt = 1'b1;
            end
            K_STOP: begin
              vel_x_nxt = '0;
              vel_y_nxt = '0;
            end
            K_DZX: begin
              if (in_chan.positive_side ? vel_x_r < 0 : vel_x_r > 0) vel_x_nxt = '0;
            end
            K_DZY: begin
              if (in_chan.positive_side ? vel_y_r < 0 : vel_y_r > 0) vel_y_nxt = '0;
            end
            K_ZX:     vel_x_nxt = '0;
            K_ZY:     vel_y_nxt = '0;
            K_NORMAL: state_nxt = S_NLEN;
            K_BRAKE:  state_nxt = S_BLEN;
            K_PRED:   state_nxt = S_MVX;
            K_LOAD: begin
              pos_x_nxt = in_chan.vec_x;
              pos_y_nxt = in_chan.vec_y;
            end
            default: ;
          endcase
        end
      end

      // Tick: take the queued velocity, then gravity and friction.
      S_TQ: begin
        if (qvalid_r) begin
          vel_x_nxt  = qv_x_r;
          vel_y_nxt  = qv_y_r;
          qvalid_nxt = 1'b0;
        end
        fax_nxt   = 1'b0;
        state_nxt = grav_en_r ? S_GRAV : (fric_en_r ? S_FINIT : S_CNORM);
      end
      S_GRAV: begin
        alu_req.op  = OP_SHR16;
        alu_req.neg = grav_r[31];
        alu_req.a   = mag32(grav_r);
        alu_req.b   = {16'd0, dt_r};
        if (call_ok) begin
          vel_y_nxt = sat_add(vel_y_r, alu_word);
          state_nxt = fric_en_r ? S_FINIT : S_CNORM;
        end
      end

      // Friction factor (1-f)^dt by repeated roots of the base.
      S_FINIT: begin
        fr_nxt    = {FR_ONE - fcl, 14'd0};
        fp_nxt    = 31'h40000000;
        fk_nxt    = 4'd15;
        state_nxt = S_FSQRT;
      end
      S_FSQRT: begin
        alu_req.op  = OP_SQRT;
        alu_req.rad = {3'b000, fr_r, 30'd0};
        if (call_ok) begin
          fr_nxt    = alu_root[30:0];
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        alu_req.op = OP_SHR30;
        alu_req.a  = {1'b0, fp_r};
        alu_req.b  = {1'b0, fr_r};
        if (!dt_r[fk_r] || call_ok) begin
          if (dt_r[fk_r]) fp_nxt = alu_word[30:0];
          fk_nxt    = fk_r - 4'd1;
          state_nxt = (fk_r == 4'd0) ? S_FAPPLY : S_FSQRT;
        end
      end
      S_FAPPLY: begin
        alu_req.op  = OP_SHR30;
        alu_req.neg = fv[31];
        alu_req.a   = mag32(fv);
        alu_req.b   = {1'b0, fp_r};
        // Components below the snap level come to rest.
        fw = (mag32(alu_word) < SNAP_LVL) ? 32'sd0 : alu_word;
        if (call_ok) begin
          if (fax_r) begin
            vel_y_nxt = fw;
            state_nxt = S_CNORM;
          end else begin
            vel_x_nxt = fw;
            fax_nxt   = 1'b1;
            state_nxt = S_FINIT;
          end
        end
      end

      // Speed clamp.
      S_CNORM: begin
        alu_req.op = OP_NORM;
        alu_req.a  = mag32(vel_x_r);
        alu_req.b  = mag32(vel_y_r);
        if (call_ok) begin
          sq_nxt    = alu_wide;
          len_nxt   = alu_root;
          state_nxt = S_CLIM;
        end
      end
      S_CLIM: begin
        alu_req.op = OP_MUL;
        alu_req.a  = {1'b0, spd_lim_r};
        alu_req.b  = {1'b0, spd_lim_r};
        if (call_ok) state_nxt = (sq_r > alu_wide) ? S_CX : S_MVX;
      end
      S_CX: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_x_r[31];
        alu_req.a   = mag32(vel_x_r);
        alu_req.b   = {1'b0, spd_lim_r};
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_x_nxt = alu_word;
          state_nxt = S_CY;
        end
      end
      S_CY: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_y_r[31];
        alu_req.a   = mag32(vel_y_r);
        alu_req.b   = {1'b0, spd_lim_r};
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_y_nxt = alu_word;
          state_nxt = S_MVX;
        end
      end

      // Position move for a tick, or the predicted position.
      S_MVX: begin
        alu_req.op  = OP_SHR16;
        alu_req.neg = vel_x_r[31];
        alu_req.a   = mag32(vel_x_r);
        alu_req.b   = {16'd0, dt_r};
        if (call_ok) begin
          if (kind_r == K_TICK) pos_x_nxt = sat_add(pos_x_r, alu_word);
          else pred_x_nxt = sat_add(pos_x_r, alu_word);
          state_nxt = S_MVY;
        end
      end
      S_MVY: begin
        alu_req.op  = OP_SHR16;
        alu_req.neg = vel_y_r[31];
        alu_req.a   = mag32(vel_y_r);
        alu_req.b   = {16'd0, dt_r};
        if (call_ok) begin
          if (kind_r == K_TICK) begin
            pos_y_nxt = sat_add(pos_y_r, alu_word);
            qv_x_nxt  = vel_x_r;
            qv_y_nxt  = vel_y_r;
          end else begin
            pred_y_nxt = sat_add(pos_y_r, alu_word);
          end
          state_nxt = S_SPD;
        end
      end

      // Force and impulse: acceleration, unit direction, then apply.
      S_ACC: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = mg_r[31];
        alu_req.a   = mag32(mg_r);
        alu_req.b   = 32'h00010000;
        alu_req.c   = {1'b0, mass_r};
        if (call_ok) begin
          acc_nxt   = alu_word;
          state_nxt = S_DIRLEN;
        end
      end
      S_DIRLEN: begin
        alu_req.op = OP_NORM;
        alu_req.a  = mag32(vx_r);
        alu_req.b  = mag32(vy_r);
        if (call_ok) begin
          len_nxt = alu_root;
          if (alu_root == 32'd0) begin
            ax_nxt    = '0;
            ay_nxt    = '0;
            state_nxt = S_DIRAPP;
          end else begin
            state_nxt = S_DIRX;
          end
        end
      end
      S_DIRX: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vx_r[31] ^ acc_r[31];
        alu_req.a   = mag32(vx_r);
        alu_req.b   = mag32(acc_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          ax_nxt    = alu_word;
          state_nxt = S_DIRY;
        end
      end
      S_DIRY: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vy_r[31] ^ acc_r[31];
        alu_req.a   = mag32(vy_r);
        alu_req.b   = mag32(acc_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          ay_nxt    = alu_word;
          state_nxt = S_DIRAPP;
        end
      end
      S_DIRAPP: begin
        state_nxt = S_SPD;
        case (kind_r)
          K_ADDF: state_nxt = S_FDTX;
          K_SETF: begin
            vel_x_nxt = ax_r;
            vel_y_nxt = ay_r;
          end
          default: begin
            vel_x_nxt = sat_add(vel_x_r, ax_r);
            vel_y_nxt = sat_add(vel_y_r, ay_r);
          end
        endcase
      end
      S_FDTX: begin
        alu_req.op  = OP_SHR16;
        alu_req.neg = ax_r[31];
        alu_req.a   = mag32(ax_r);
        alu_req.b   = {16'd0, dt_r};
        if (call_ok) begin
          vel_x_nxt = sat_add(vel_x_r, alu_word);
          state_nxt = S_FDTY;
        end
      end
      S_FDTY: begin
        alu_req.op  = OP_SHR16;
        alu_req.neg = ay_r[31];
        alu_req.a   = mag32(ay_r);
        alu_req.b   = {16'd0, dt_r};
        if (call_ok) begin
          vel_y_nxt = sat_add(vel_y_r, alu_word);
          state_nxt = S_SPD;
        end
      end

      // Contact normal: remove the velocity part that moves into it.
      S_NLEN: begin
        alu_req.op = OP_NORM;
        alu_req.a  = mag32(vx_r);
        alu_req.b  = mag32(vy_r);
        if (call_ok) begin
          len_nxt   = alu_root;
          state_nxt = (alu_wide > NORM_LIM) ? S_NDX : S_SPD;
        end
      end
      S_NDX: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_x_r[31] ^ vx_r[31];
        alu_req.a   = mag32(vel_x_r);
        alu_req.b   = mag32(vx_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          t0_nxt    = alu_word;
          state_nxt = S_NDY;
        end
      end
      S_NDY: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_y_r[31] ^ vy_r[31];
        alu_req.a   = mag32(vel_y_r);
        alu_req.b   = mag32(vy_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          t0_nxt    = dot;
          state_nxt = dot[31] ? S_NVX : S_SPD;
        end
      end
      S_NVX: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vx_r[31];
        alu_req.a   = mag32(vx_r);
        alu_req.b   = mag32(t0_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_x_nxt = sat_add(vel_x_r, alu_word);
          state_nxt = S_NVY;
        end
      end
      S_NVY: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vy_r[31];
        alu_req.a   = mag32(vy_r);
        alu_req.b   = mag32(t0_r);
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_y_nxt = sat_add(vel_y_r, alu_word);
          state_nxt = S_SPD;
        end
      end

      // Brake: shrink the speed by rate times dt, or stop when slow.
      S_BLEN: begin
        alu_req.op = OP_NORM;
        alu_req.a  = mag32(vel_x_r);
        alu_req.b  = mag32(vel_y_r);
        if (call_ok) begin
          len_nxt = alu_root;
          if (alu_root <= SNAP_LVL) begin
            vel_x_nxt = '0;
            vel_y_nxt = '0;
            state_nxt = S_SPD;
          end else begin
            state_nxt = S_BDEC;
          end
        end
      end
      S_BDEC: begin
        alu_req.op = OP_SHR16;
        alu_req.a  = {1'b0, brake_r};
        alu_req.b  = {16'd0, dt_r};
        if (call_ok) begin
          ns_nxt    = (len_r > dec) ? (len_r - dec) : 32'd0;
          state_nxt = S_BX;
        end
      end
      S_BX: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_x_r[31];
        alu_req.a   = mag32(vel_x_r);
        alu_req.b   = ns_r;
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_x_nxt = alu_word;
          state_nxt = S_BY;
        end
      end
      S_BY: begin
        alu_req.op  = OP_DIV;
        alu_req.neg = vel_y_r[31];
        alu_req.a   = mag32(vel_y_r);
        alu_req.b   = ns_r;
        alu_req.c   = len_r;
        if (call_ok) begin
          vel_y_nxt = alu_word;
          state_nxt = S_SPD;
        end
      end

      // Speed of the final velocity, then load the output register.
      S_SPD: begin
        alu_req.op = OP_NORM;
        alu_req.a  = mag32(vel_x_r);
        alu_req.b  = mag32(vel_y_r);
        if (call_ok) begin
          o_px_nxt   = pos_x_r;
          o_py_nxt   = pos_y_r;
          o_vx_nxt   = vel_x_r;
          o_vy_nxt   = vel_y_r;
          o_prx_nxt  = pred_x_r;
          o_pry_nxt  = pred_y_r;
          o_spd_nxt  = alu_root[31] ? SPEED_MAX : alu_root[30:0];
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Unit handshake shared by every step that calls it.
    if (state_r != S_IDLE && state_r != S_TQ && state_r != S_FINIT &&
        state_r != S_DIRAPP && state_r != S_OUT &&
        !(state_r == S_FMUL && !dt_r[fk_r])) begin
      if (!pend_r) begin
        alu_start = 1'b1;
        pend_nxt  = 1'b1;
      end else if (alu_done) begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= 1'b0;
      ovalid_r  <= 1'b0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      qv_x_r    <= '0;
      qv_y_r    <= '0;
      qvalid_r  <= 1'b0;
      grav_r    <= '0;
      grav_en_r <= 1'b0;
      fric_x_r  <= '0;
      fric_y_r  <= '0;
      fric_en_r <= 1'b0;
      spd_lim_r <= SPEED_MAX;
      mass_r    <= 31'h00010000;
      brake_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      ovalid_r  <= ovalid_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      vel_x_r   <= vel_x_nxt;
      vel_y_r   <= vel_y_nxt;
      qv_x_r    <= qv_x_nxt;
      qv_y_r    <= qv_y_nxt;
      qvalid_r  <= qvalid_nxt;
      grav_r    <= grav_nxt;
      grav_en_r <= grav_en_nxt;
      fric_x_r  <= fric_x_nxt;
      fric_y_r  <= fric_y_nxt;
      fric_en_r <= fric_en_nxt;
      spd_lim_r <= spd_lim_nxt;
      mass_r    <= mass_nxt;
      brake_r   <= brake_nxt;
    end
    kind_r   <= kind_nxt;
    dt_r     <= dt_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    mg_r     <= mg_nxt;
    acc_r    <= acc_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    t0_r     <= t0_nxt;
    pred_x_r <= pred_x_nxt;
    pred_y_r <= pred_y_nxt;
    len_r    <= len_nxt;
    ns_r     <= ns_nxt;
    sq_r     <= sq_nxt;
    fax_r    <= fax_nxt;
    fr_r     <= fr_nxt;
    fp_r     <= fp_nxt;
    fk_r     <= fk_nxt;
    o_px_r   <= o_px_nxt;
    o_py_r   <= o_py_nxt;
    o_vx_r   <= o_vx_nxt;
    o_vy_r   <= o_vy_nxt;
    o_prx_r  <= o_prx_nxt;
    o_pry_r  <= o_pry_nxt;
    o_spd_r  <= o_spd_nxt;
  end

  // Channel outputs.
  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = ovalid_r;
  assign out_chan.position_x  = o_px_r;
  assign out_chan.position_y  = o_py_r;
  assign out_chan.velocity_x  = o_vx_r;
  assign out_chan.velocity_y  = o_vy_r;
  assign out_chan.speed       = o_spd_r;
  assign out_chan.predicted_x = o_prx_r;
  assign out_chan.predicted_y = o_pry_r;

  // Checks on the sequencer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_chan.valid)
    else $error("input taken while a result word is pending");

  a_tick_clears_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPD && kind_r == K_TICK) |-> !qvalid_r)
    else $error("queued velocity still pending after a tick");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> pend_r)
    else $error("arithmetic unit finished with no call outstanding");

  a_result_from_speed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_SPD)
    else $error("result word raised outside the speed step");

endmodule

>>> verif/rigid_body_2d_integrator_unit_tb.sv
// Self-checking testbench for the 2D rigid body integrator, with a built-in body predictor.
`timescale 1ns / 1ps
module rigid_body_2d_integrator_unit_tb;
  import rbi_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    logic [3:0]         kind;
    logic [15:0]        dt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] mg;
    logic               ps;
  } body_cmd_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        spd;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
  } body_report_t;

  logic clk;
  logic rst_n;

  rbi_in_if  in_ch ();
  rbi_out_if out_ch ();
  rbi_cfg_if cfg_ch ();

  rigid_body_2d_integrator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  body_cmd_t    cmd_q[$];
  body_report_t report_q[$];
  int           errors = 0;
  int           cycles = 0;

  // Predictor copy of the registers.
  longint      grav = 0;
  bit          grav_en = 0;
  logic [16:0] fric_x = '0;
  logic [16:0] fric_y = '0;
  bit          fric_en = 0;
  logic [30:0] spd_lim = SPEED_MAX;
  logic [30:0] mass = 31'd65536;
  logic [30:0] brake = '0;

  // Predictor copy of the body state.
  longint pos_x = 0, pos_y = 0, vel_x = 0, vel_y = 0, qvel_x = 0, qvel_y = 0;
  bit     qvel_pend = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sadd(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  // Floor square root of a 128-bit value.
  function automatic logic [63:0] root(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= n) r = c;
    end
    return r;
  endfunction

  // Truncated (a*b)/c with a sign, saturated to the word.
  function automatic longint scaled(input bit neg, input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] c);
    logic [127:0] q;
    if (c == 0) return 0;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
    if (q == 0) return 0;
    if (neg) return (q > 128'h80000000) ? -64'sd2147483648 : -longint'(q[63:0]);
    return (q > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(q[63:0]);
  endfunction

  function automatic logic [127:0] sqsum(input longint a, input longint b);
    return {64'd0, mag(a)} * {64'd0, mag(a)} + {64'd0, mag(b)} * {64'd0, mag(b)};
  endfunction

  function automatic longint times_dt(input longint v, input logic [15:0] dt);
    return scaled(v < 0, mag(v), 64'(dt), 64'd65536);
  endfunction

  // Velocity scaled by (1-f)^dt through repeated roots in Q0.30, then the small-speed snap.
  function automatic longint damp(input longint v, input logic [16:0] f, input logic [15:0] dt);
    logic [63:0] r;
    logic [63:0] p;
    longint      res;
    if (f > FR_ONE) f = FR_ONE;
    r = 64'(FR_ONE - f) << 14;
    p = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      r = root({64'd0, r << 30});
      if (dt[16 - i]) p = (p * r) >> 30;
    end
    res = scaled(v < 0, mag(v), p, 64'd1 << 30);
    if (mag(res) < 64'(SNAP_LVL)) res = 0;
    return res;
  endfunction

  // Unit direction of (dx,dy) times the signed amount a.
  task automatic dir_scale(input longint dx, input longint dy, input longint a,
                           output longint ox, output longint oy);
    logic [63:0] len;
    len = root(sqsum(dx, dy));
    ox = scaled((dx < 0) != (a < 0), mag(dx), mag(a), len);
    oy = scaled((dy < 0) != (a < 0), mag(dy), mag(a), len);
  endtask

  // ---------------------------------------------------------------- predictor
  task automatic cfg_apply(input logic [3:0] idx, input logic [31:0] d);
    case (idx)
      R_GRAV:    grav = longint'(signed'(d));
      R_GRAV_EN: grav_en = d[0];
      R_FRIC_X:  fric_x = d[16:0];
      R_FRIC_Y:  fric_y = d[16:0];
      R_FRIC_EN: fric_en = d[0];
      R_SPD_LIM: spd_lim = d[30:0];
      R_MASS:    mass = (d[30:0] < MASS_MIN) ? MASS_MIN : d[30:0];
      R_BRAKE:   brake = d[30:0];
      default: ;
    endcase
  endtask

  task automatic body_step(input body_cmd_t c);
    longint       ax, ay, acc, dot, pdx, pdy, dx, dy, mg;
    logic [63:0]  s, dec, ns, len;
    logic [127:0] sq;
    body_report_t rep;
    dx = longint'(c.vx);
    dy = longint'(c.vy);
    mg = longint'(c.mg);
    pdx = 0;
    pdy = 0;
    acc = scaled(mg < 0, mag(mg), 64'd65536, 64'(mass));
    case (c.kind)
      K_TICK: begin
        if (qvel_pend) begin
          vel_x = qvel_x;
          vel_y = qvel_y;
          qvel_pend = 0;
        end
        if (grav_en) vel_y = sadd(vel_y, times_dt(grav, c.dt));
        if (fric_en) begin
          vel_x = damp(vel_x, fric_x, c.dt);
          vel_y = damp(vel_y, fric_y, c.dt);
        end
        sq = sqsum(vel_x, vel_y);
        if (sq > {97'd0, spd_lim} * {97'd0, spd_lim}) begin
          s = root(sq);
          vel_x = scaled(vel_x < 0, mag(vel_x), 64'(spd_lim), s);
          vel_y = scaled(vel_y < 0, mag(vel_y), 64'(spd_lim), s);
        end
        pos_x = sadd(pos_x, times_dt(vel_x, c.dt));
        pos_y = sadd(pos_y, times_dt(vel_y, c.dt));
        qvel_x = vel_x;
        qvel_y = vel_y;
      end
      K_ADDF: begin
        dir_scale(dx, dy, acc, ax, ay);
        vel_x = sadd(vel_x, times_dt(ax, c.dt));
        vel_y = sadd(vel_y, times_dt(ay, c.dt));
      end
      K_SETF: begin
        dir_scale(dx, dy, acc, ax, ay);
        vel_x = ax;
        vel_y = ay;
      end
      K_IMP: begin
        dir_scale(dx, dy, acc, ax, ay);
        vel_x = sadd(vel_x, ax);
        vel_y = sadd(vel_y, ay);
      end
      K_QVEL: begin
        qvel_x = dx;
        qvel_y = dy;
        qvel_pend = 1;
      end
      K_STOP: begin
        vel_x = 0;
        vel_y = 0;
      end
      K_DZX: if (c.ps ? vel_x < 0 : vel_x > 0) vel_x = 0;
      K_DZY: if (c.ps ? vel_y < 0 : vel_y > 0) vel_y = 0;
      K_ZX: vel_x = 0;
      K_ZY: vel_y = 0;
      K_NORMAL: begin
        sq = sqsum(dx, dy);
        if (sq > {64'd0, NORM_LIM}) begin
          len = root(sq);
          dot = sadd(scaled((vel_x < 0) != (dx < 0), mag(vel_x), mag(dx), len),
                     scaled((vel_y < 0) != (dy < 0), mag(vel_y), mag(dy), len));
          if (dot < 0) begin
            vel_x = sadd(vel_x, scaled(dx < 0, mag(dx), mag(dot), len));
            vel_y = sadd(vel_y, scaled(dy < 0, mag(dy), mag(dot), len));
          end
        end
      end
      K_BRAKE: begin
        s = root(sqsum(vel_x, vel_y));
        if (s <= 64'(SNAP_LVL)) begin
          vel_x = 0;
          vel_y = 0;
        end else begin
          dec = mag(times_dt(longint'(brake), c.dt));
          ns = (s > dec) ? s - dec : 64'd0;
          vel_x = scaled(vel_x < 0, mag(vel_x), ns, s);
          vel_y = scaled(vel_y < 0, mag(vel_y), ns, s);
        end
      end
      K_PRED: begin
        pdx = sadd(pos_x, times_dt(vel_x, c.dt));
        pdy = sadd(pos_y, times_dt(vel_y, c.dt));
      end
      K_LOAD: begin
        pos_x = dx;
        pos_y = dy;
      end
      default: ;
    endcase
    s = root(sqsum(vel_x, vel_y));
    rep.pos_x = 32'(pos_x);
    rep.pos_y = 32'(pos_y);
    rep.vel_x = 32'(vel_x);
    rep.vel_y = 32'(vel_y);
    rep.spd = (s > 64'(SPEED_MAX)) ? SPEED_MAX : s[30:0];
    rep.pred_x = 32'(pdx);
    rep.pred_y = 32'(pdy);
    report_q.push_back(rep);
  endtask

  // ---------------------------------------------------------------- driver
  body_cmd_t cur_cmd;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // The word on the bus was taken at this edge.
      if (in_ch.valid && in_ch.ready) body_step(cur_cmd);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_ch.kind <= cur_cmd.kind;
          in_ch.time_step <= cur_cmd.dt;
          in_ch.vec_x <= cur_cmd.vx;
          in_ch.vec_y <= cur_cmd.vy;
          in_ch.magnitude <= cur_cmd.mg;
          in_ch.positive_side <= cur_cmd.ps;
          in_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver and monitor
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         pat_left = 0;
  logic [7:0] stall_mask;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    body_report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, expected none actual pos %0d,%0d",
                   $time, out_ch.position_x, out_ch.position_y);
        end else begin
          want = report_q.pop_front();
          check_field("position_x", want.pos_x, out_ch.position_x);
          check_field("position_y", want.pos_y, out_ch.position_y);
          check_field("velocity_x", want.vel_x, out_ch.velocity_x);
          check_field("velocity_y", want.vel_y, out_ch.velocity_y);
          check_field("speed", want.spd, out_ch.speed);
          check_field("predicted_x", want.pred_x, out_ch.predicted_x);
          check_field("predicted_y", want.pred_y, out_ch.predicted_y);
        end
      end
      // A long hold-off when asked, else a random eight-bit stall mask, renewed once all its bits are used.
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom & $urandom);
          pat_left = 8;
        end
        pat_left--;
        out_ch.ready <= ~stall_mask[pat_left];
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_cmd(input logic [3:0] k, input logic [15:0] dt, input logic [31:0] x,
                         input logic [31:0] y, input logic [31:0] m, input logic ps);
    body_cmd_t c;
    c.kind = k;
    c.dt = dt;
    c.vx = x;
    c.vy = y;
    c.mg = m;
    c.ps = ps;
    cmd_q.push_back(c);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_apply(idx, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every queued word is taken and every result has come back.
  task automatic drain();
    while (cmd_q.size() > 0 || in_ch.valid || report_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1, 2, 3: begin
        w = $urandom_range(0, 32'h00100000);
        if ($urandom_range(0, 1)) w = -w;
      end
      4: w = $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return K_TICK;
    if (r < 30) return $urandom_range(0, 1) ? 4'd14 : 4'd15;
    return 4'($urandom_range(1, 13));
  endfunction

  task automatic add_random(input int n);
    logic [15:0] dt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: dt = '0;
        1: dt = 16'hFFFF;
        2: dt = 16'($urandom_range(0, 16'h0800));
        default: dt = 16'($urandom);
      endcase
      add_cmd(rand_kind(), dt, rand_word(), rand_word(), rand_word(),
              1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.time_step = '0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.magnitude = '0;
    in_ch.positive_side = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset registers.
    add_cmd(K_PRED, 16'hFFFF, 0, 0, 0, 0);
    add_cmd(K_IMP, 16'h0000, 32'h00010000, 0, 32'h00030000, 0);
    add_cmd(K_ADDF, 16'hFFFF, 0, 32'hFFFB0000, 32'h7FFFFFFF, 0);
    add_cmd(K_SETF, 16'h1000, 0, 0, 32'h00010000, 0);          // zero direction
    add_cmd(K_IMP, 16'h0000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
    add_cmd(K_QVEL, 16'h0000, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    add_cmd(K_STOP, 16'h0000, 0, 0, 0, 0);                     // queue survives a stop
    add_cmd(K_TICK, 16'h8000, 0, 0, 0, 0);
    add_cmd(K_DZX, 16'h0000, 0, 0, 0, 1);
    add_cmd(K_DZX, 16'h0000, 0, 0, 0, 0);
    add_cmd(K_DZY, 16'h0000, 0, 0, 0, 0);
    add_cmd(K_DZY, 16'h0000, 0, 0, 0, 1);
    add_cmd(K_SETF, 16'h0000, 32'h00020000, 32'h00030000, 32'h00040000, 0);
    add_cmd(K_NORMAL, 16'h0000, 32'd10, 32'd10, 0, 0);         // normal too short
    add_cmd(K_NORMAL, 16'h0000, 32'hFFFF0000, 0, 0, 0);
    add_cmd(K_ZX, 16'h0000, 0, 0, 0, 0);
    add_cmd(K_ZY, 16'h0000, 0, 0, 0, 0);
    add_cmd(K_IMP, 16'h0000, 32'h00010000, 32'h00010000, 32'd300, 0);
    add_cmd(K_BRAKE, 16'h4000, 0, 0, 0, 0);                    // slow body stops
    add_cmd(K_LOAD, 16'h0000, 32'h80000000, 32'h7FFFFFFF, 0, 0);
    add_cmd(K_TICK, 16'h0000, 0, 0, 0, 0);
    add_cmd(4'd14, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    add_cmd(4'd15, 16'h0000, 0, 0, 0, 0);
    add_cmd(K_PRED, 16'hFFFF, 0, 0, 0, 0);
    drain();

    // Gravity at its negative extreme, tight speed limit, light brake.
    write_reg(R_GRAV, 32'h80000000);
    write_reg(R_GRAV_EN, 32'd1);
    write_reg(R_SPD_LIM, 32'h00500000);
    write_reg(R_BRAKE, 32'h00020000);
    add_random(100);
    drain();

    // Friction at full, above full and partial; receiver holds off at the start.
    write_reg(R_FRIC_X, 32'h0001FFFF);
    write_reg(R_FRIC_Y, 32'h00008000);
    write_reg(R_FRIC_EN, 32'd1);
    write_reg(R_GRAV, 32'h7FFFFFFF);
    hold_req++;
    add_random(80);
    drain();
    write_reg(R_FRIC_X, 32'h00010000);
    write_reg(R_FRIC_Y, 32'h00000000);
    add_random(30);
    drain();

    // Mass clamped to its minimum, zero speed limit, maximum brake.
    write_reg(R_FRIC_EN, 32'd0);
    write_reg(R_MASS, 32'd0);
    write_reg(R_SPD_LIM, 32'd0);
    write_reg(R_BRAKE, 32'h7FFFFFFF);
    add_random(100);
    drain();

    // Heaviest body, no limit, random registers.
    write_reg(R_MASS, 32'h7FFFFFFF);
    write_reg(R_SPD_LIM, 32'h7FFFFFFF);
    write_reg(R_GRAV, $urandom);
    write_reg(R_GRAV_EN, 32'd0);
    write_reg(R_BRAKE, $urandom_range(0, 32'h00100000));
    add_random(50);
    drain();
    write_reg(R_MASS, $urandom_range(32'h00004000, 32'h00040000));
    write_reg(R_GRAV_EN, 32'd1);
    write_reg(R_GRAV, $urandom_range(0, 32'h000A0000));
    add_random(60);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && report_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
